### hw/rtl/mfw_pkg.sv
// ----------------------------------------------------------------------------
// mfw_pkg
// Shared widths, constants and types of the Mitchell filter weight core.
// ----------------------------------------------------------------------------
package mfw_pkg;

   localparam int FRAC_BITS   = 14;
   localparam int OFF_FRAC    = 12;
   localparam int OFF_W       = 16;
   localparam int REG_W       = 16;
   localparam int OUT_W       = 16;

   localparam int ONE         = 1 << FRAC_BITS;
   localparam int HALF        = ONE >> 1;

   localparam int PROD1_W     = OFF_W + REG_W;
   localparam int TF_W        = PROD1_W - OFF_FRAC + 2;
   localparam int T_W         = FRAC_BITS + 1;
   localparam int T2_W        = T_W + 1;
   localparam int T3_W        = T2_W + 1;
   localparam int COEF_W      = 22;
   localparam int PROD_W      = COEF_W + T3_W + 1;
   localparam int SUM_W       = PROD_W + 2;
   localparam int V_W         = SUM_W - FRAC_BITS - 1;
   localparam int RECIP_W     = 32;
   localparam int RECIP_SHIFT = 33;
   localparam int QPROD_W     = V_W + RECIP_W;
   localparam int Q_W         = QPROD_W - RECIP_SHIFT;
   localparam int WGT_W       = Q_W + 1;
   localparam int WPROD_W     = 2 * WGT_W;

   localparam int AX_STAGES   = 9;
   localparam int LAT         = AX_STAGES + 2;

   localparam logic [RECIP_W-1:0] RECIP3 = 32'hAAAA_AAAB;

   localparam logic signed [COEF_W-1:0] K6   = COEF_W'(6 * ONE);
   localparam logic signed [COEF_W-1:0] K12  = COEF_W'(12 * ONE);
   localparam logic signed [COEF_W-1:0] K18  = COEF_W'(18 * ONE);

   localparam logic signed [REG_W-1:0] B_RESET   = 16'sd5461;
   localparam logic signed [REG_W-1:0] C_RESET   = 16'sd5461;
   localparam logic [REG_W-1:0]        INV_RESET = 16'd8192;

   typedef enum logic [1:0] {
      CSR_B_COEFF     = 2'd0,
      CSR_C_COEFF     = 2'd1,
      CSR_INV_X_WIDTH = 2'd2,
      CSR_INV_Y_WIDTH = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] in3;
      logic signed [COEF_W-1:0] in2;
      logic signed [COEF_W-1:0] in0;
      logic signed [COEF_W-1:0] out3;
      logic signed [COEF_W-1:0] out2;
      logic signed [COEF_W-1:0] out1;
      logic signed [COEF_W-1:0] out0;
   } coef_type;

endpackage

### hw/rtl/mfw_axis.sv
// ----------------------------------------------------------------------------
// mfw_axis
// Pipelined Mitchell-Netravali cubic weight of one axis offset.
// ----------------------------------------------------------------------------
module mfw_axis (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   valid,
   input  logic signed [mfw_pkg::OFF_W-1:0]       offset,
   input  logic [mfw_pkg::REG_W-1:0]              inv_width,
   input  mfw_pkg::coef_type                      coef,
   output logic                                   weight_valid,
   output logic signed [mfw_pkg::WGT_W-1:0]       weight
);
   import mfw_pkg::*;

   logic [AX_STAGES-1:0]       vld_ff, vld_in;

   logic [OFF_W-1:0]           mag;
   logic [PROD1_W-1:0]         prod1_ff, prod1_in;

   logic [PROD1_W:0]           tsum;
   logic [TF_W-1:0]            tfull;
   logic [T_W-1:0]             t_s2_ff, t_s2_in;
   logic                       far_s2_ff, far_s2_in;

   logic [2*T_W-1:0]           tsq_s3_ff, tsq_s3_in;
   logic [T_W-1:0]             t_s3_ff;
   logic                       far_s3_ff, inner_s3_ff, inner_s3_in;

   logic [2*T_W-1:0]           t2sum;
   logic [T2_W-1:0]            t2;
   logic [T2_W+T_W-1:0]        t2t_s4_ff, t2t_s4_in;
   logic [T2_W-1:0]            t2_s4_ff;
   logic [T_W-1:0]             t_s4_ff;
   logic                       far_s4_ff, inner_s4_ff;

   logic [T2_W+T_W-1:0]        t3sum;
   logic [T3_W-1:0]            t3;
   logic signed [COEF_W-1:0]   c3_sel, c2_sel, c1_sel, c0_sel;
   logic signed [PROD_W-1:0]   p3_s5_ff, p3_s5_in, p2_s5_ff, p2_s5_in, p1_s5_ff, p1_s5_in;
   logic signed [COEF_W-1:0]   c0_s5_ff;
   logic                       far_s5_ff;

   logic signed [SUM_W-1:0]    sum_s6_ff, sum_s6_in;
   logic                       far_s6_ff;

   logic                       neg;
   logic [SUM_W-1:0]           smag, radd;
   logic [V_W-1:0]             v_s7_ff, v_s7_in;
   logic                       neg_s7_ff, far_s7_ff;

   logic [QPROD_W-1:0]         qprod_s8_ff, qprod_s8_in;
   logic                       neg_s8_ff, far_s8_ff;

   logic [Q_W-1:0]             q;
   logic signed [WGT_W-1:0]    qs;
   logic signed [WGT_W-1:0]    weight_ff, weight_in;

   always_comb begin
      vld_in = {vld_ff[AX_STAGES-2:0], valid};

      mag      = offset[OFF_W-1] ? OFF_W'(-offset) : offset;
      prod1_in = PROD1_W'(mag) * PROD1_W'(inv_width);

      tsum      = (PROD1_W+1)'(prod1_ff) + (PROD1_W+1)'(1 << (OFF_FRAC - 2));
      tfull     = tsum[PROD1_W:OFF_FRAC-1];
      far_s2_in = tfull >= TF_W'(2 * ONE);
      t_s2_in   = tfull[T_W-1:0];

      tsq_s3_in   = (2*T_W)'(t_s2_ff) * (2*T_W)'(t_s2_ff);
      inner_s3_in = t_s2_ff <= T_W'(ONE);

      t2sum     = tsq_s3_ff + (2*T_W)'(HALF);
      t2        = t2sum[2*T_W-1:FRAC_BITS];
      t2t_s4_in = (T2_W+T_W)'(t2) * (T2_W+T_W)'(t_s3_ff);

      t3sum  = t2t_s4_ff + (T2_W+T_W)'(HALF);
      t3     = t3sum[T2_W+T_W-1:FRAC_BITS];
      c3_sel = inner_s4_ff ? coef.in3 : coef.out3;
      c2_sel = inner_s4_ff ? coef.in2 : coef.out2;
      c1_sel = inner_s4_ff ? '0 : coef.out1;
      c0_sel = inner_s4_ff ? coef.in0 : coef.out0;
      p3_s5_in = PROD_W'(c3_sel) * PROD_W'($signed({1'b0, t3}));
      p2_s5_in = PROD_W'(c2_sel) * PROD_W'($signed({1'b0, t2_s4_ff}));
      p1_s5_in = PROD_W'(c1_sel) * PROD_W'($signed({1'b0, t_s4_ff}));

      sum_s6_in = SUM_W'(p3_s5_ff) + SUM_W'(p2_s5_ff) + SUM_W'(p1_s5_ff)
                + (SUM_W'(c0_s5_ff) <<< FRAC_BITS);

      neg     = sum_s6_ff[SUM_W-1];
      smag    = neg ? SUM_W'(-sum_s6_ff) : SUM_W'(sum_s6_ff);
      radd    = smag + SUM_W'(3 * ONE);
      v_s7_in = radd[SUM_W-1:FRAC_BITS+1];

      qprod_s8_in = QPROD_W'(v_s7_ff) * QPROD_W'(RECIP3);

      q  = qprod_s8_ff[QPROD_W-1:RECIP_SHIFT];
      qs = $signed({1'b0, q});
      if (far_s8_ff) begin
         weight_in = '0;
      end else if (neg_s8_ff) begin
         weight_in = -qs;
      end else begin
         weight_in = qs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      prod1_ff    <= prod1_in;
      t_s2_ff     <= t_s2_in;
      far_s2_ff   <= far_s2_in;
      tsq_s3_ff   <= tsq_s3_in;
      t_s3_ff     <= t_s2_ff;
      far_s3_ff   <= far_s2_ff;
      inner_s3_ff <= inner_s3_in;
      t2t_s4_ff   <= t2t_s4_in;
      t2_s4_ff    <= t2;
      t_s4_ff     <= t_s3_ff;
      far_s4_ff   <= far_s3_ff;
      inner_s4_ff <= inner_s3_ff;
      p3_s5_ff    <= p3_s5_in;
      p2_s5_ff    <= p2_s5_in;
      p1_s5_ff    <= p1_s5_in;
      c0_s5_ff    <= c0_sel;
      far_s5_ff   <= far_s4_ff;
      sum_s6_ff   <= sum_s6_in;
      far_s6_ff   <= far_s5_ff;
      v_s7_ff     <= v_s7_in;
      neg_s7_ff   <= neg;
      far_s7_ff   <= far_s6_ff;
      qprod_s8_ff <= qprod_s8_in;
      neg_s8_ff   <= neg_s7_ff;
      far_s8_ff   <= far_s7_ff;
      weight_ff   <= weight_in;
   end

   assign weight_valid = vld_ff[AX_STAGES-1];
   assign weight       = weight_ff;

   a_far_tail_zero: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[AX_STAGES-2] && far_s8_ff) |=> (weight_ff == '0))
      else $error("far tail item gave a nonzero weight");

   a_div3_exact: assert property (@(posedge clock) disable iff (reset)
      vld_ff[AX_STAGES-3] |=>
         ((V_W'(q) * V_W'(3) <= $past(v_s7_ff))
          && ($past(v_s7_ff) - V_W'(q) * V_W'(3) < V_W'(3))))
      else $error("reciprocal divide by three is off");

endmodule

### hw/rtl/mitchell_filter_weight_core.sv
// ----------------------------------------------------------------------------
// mitchell_filter_weight_core
// Separable Mitchell-Netravali filter weight of a sample offset, fixed point.
// ----------------------------------------------------------------------------
// One item (x, y offset) enters on any cycle with start high; busy stays low,
// so a new item is taken every clock. The weight appears on rsp_filter_weight
// with rsp_valid high for one cycle, after nine stages per axis (scale,
// square, cube, coefficient products, sum, round, reciprocal divide by three,
// sign) and two for the axis product and the final round and saturate. The
// receiver cannot stall, so results must be taken as they come. Configuration
// writes belong in idle periods with no item in flight; they take effect once
// the settings registers and, for B and C, the coefficient register are loaded.
// ----------------------------------------------------------------------------
module mitchell_filter_weight_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [mfw_pkg::OFF_W-1:0]    req_x_offset,
   input  logic signed [mfw_pkg::OFF_W-1:0]    req_y_offset,
   input  logic                                csr_we,
   input  logic [1:0]                          csr_index,
   input  logic [mfw_pkg::REG_W-1:0]           csr_wdata,
   output logic                                rsp_valid,
   output logic signed [mfw_pkg::OUT_W-1:0]    rsp_filter_weight
);
   import mfw_pkg::*;

   localparam int RQ_W = WPROD_W - FRAC_BITS;
   localparam logic signed [RQ_W-1:0] SAT_HI = RQ_W'(32767);
   localparam logic signed [RQ_W-1:0] SAT_LO = -RQ_W'(32768);

   logic signed [REG_W-1:0]    b_ff, b_in, c_ff, c_in;
   logic [REG_W-1:0]           inv_x_ff, inv_x_in, inv_y_ff, inv_y_in;
   logic signed [COEF_W-1:0]   b_x, c_x;
   coef_type                   coef_ff, coef_in;

   logic                       accept;
   logic                       wx_vld, wy_vld;
   logic signed [WGT_W-1:0]    wx, wy;

   logic                       prod_vld_ff, prod_vld_in;
   logic signed [WPROD_W-1:0]  wprod_ff, wprod_in;
   logic signed [WPROD_W-1:0]  rsum;
   logic signed [RQ_W-1:0]     rq;

   logic                       rsp_valid_ff;
   logic signed [OUT_W-1:0]    rsp_weight_ff, rsp_weight_in;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   always_comb begin
      b_in     = b_ff;
      c_in     = c_ff;
      inv_x_in = inv_x_ff;
      inv_y_in = inv_y_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_B_COEFF:     b_in     = $signed(csr_wdata);
            CSR_C_COEFF:     c_in     = $signed(csr_wdata);
            CSR_INV_X_WIDTH: inv_x_in = csr_wdata;
            CSR_INV_Y_WIDTH: inv_y_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff     <= B_RESET;
         c_ff     <= C_RESET;
         inv_x_ff <= INV_RESET;
         inv_y_ff <= INV_RESET;
      end else begin
         b_ff     <= b_in;
         c_ff     <= c_in;
         inv_x_ff <= inv_x_in;
         inv_y_ff <= inv_y_in;
      end
   end

   always_comb begin
      b_x = COEF_W'(b_ff);
      c_x = COEF_W'(c_ff);
      coef_in.in3  = K12 - 22'sd9 * b_x - 22'sd6 * c_x;
      coef_in.in2  = -K18 + 22'sd12 * b_x + 22'sd6 * c_x;
      coef_in.in0  = K6 - 22'sd2 * b_x;
      coef_in.out3 = -b_x - 22'sd6 * c_x;
      coef_in.out2 = 22'sd6 * b_x + 22'sd30 * c_x;
      coef_in.out1 = -(22'sd12 * b_x) - 22'sd48 * c_x;
      coef_in.out0 = 22'sd8 * b_x + 22'sd24 * c_x;
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_in;
   end

   mfw_axis u_axis_x (
      .clock        (clock),
      .reset        (reset),
      .valid        (accept),
      .offset       (req_x_offset),
      .inv_width    (inv_x_ff),
      .coef         (coef_ff),
      .weight_valid (wx_vld),
      .weight       (wx)
   );

   mfw_axis u_axis_y (
      .clock        (clock),
      .reset        (reset),
      .valid        (accept),
      .offset       (req_y_offset),
      .inv_width    (inv_y_ff),
      .coef         (coef_ff),
      .weight_valid (wy_vld),
      .weight       (wy)
   );

   always_comb begin
      prod_vld_in = wx_vld;
      wprod_in    = WPROD_W'(wx) * WPROD_W'(wy);

      if (wprod_ff[WPROD_W-1]) begin
         rsum = wprod_ff + WPROD_W'(HALF - 1);
      end else begin
         rsum = wprod_ff + WPROD_W'(HALF);
      end
      rq = rsum[WPROD_W-1:FRAC_BITS];

      if (rq > SAT_HI) begin
         rsp_weight_in = OUT_W'(SAT_HI);
      end else if (rq < SAT_LO) begin
         rsp_weight_in = OUT_W'(SAT_LO);
      end else begin
         rsp_weight_in = OUT_W'(rq);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= prod_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      wprod_ff      <= wprod_in;
      rsp_weight_ff <= rsp_weight_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filter_weight = rsp_weight_ff;

   a_axes_aligned: assert property (@(posedge clock) disable iff (reset)
      wx_vld == wy_vld)
      else $error("axis pipelines out of step");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT))
      else $error("result without an item taken at the pipeline latency");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Mitchell-Netravali filter weight core.
// ----------------------------------------------------------------------------
// Offset pairs go in as bursts of items with random gaps between the bursts.
// Every accepted item is run through a fixed-point model of the separable
// cubic filter, and the weight it should give is queued. Each strobed result
// is checked against the oldest queued weight. The filter registers are
// reloaded between phases, once no weight is outstanding. The settings cover
// the reset values, B zero with C one half, zero widths, the most negative and
// most positive B and C, full-scale widths and random settings. The offsets
// are chosen so that the scaled distance falls on the inner piece, the outer
// piece and the far tail of the cubic.
// ----------------------------------------------------------------------------
module testbench;
   import mfw_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASES         = 6;
   localparam int RANDOM_ITEMS   = 190;

   class weight_scoreboard;
      longint                   b_coeff;
      longint                   c_coeff;
      logic [REG_W-1:0]         inv_x;
      logic [REG_W-1:0]         inv_y;
      logic signed [OUT_W-1:0]  expected_weight[$];
      int                       errors;
      int                       checked;

      function new();
         b_coeff = B_RESET;
         c_coeff = C_RESET;
         inv_x   = INV_RESET;
         inv_y   = INV_RESET;
         errors  = 0;
         checked = 0;
      endfunction

      function void set_reg(csr_idx_type idx, logic [REG_W-1:0] val);
         case (idx)
            CSR_B_COEFF:     b_coeff = longint'(signed'(val));
            CSR_C_COEFF:     c_coeff = longint'(signed'(val));
            CSR_INV_X_WIDTH: inv_x   = val;
            CSR_INV_Y_WIDTH: inv_y   = val;
            default: ;
         endcase
      endfunction

      function longint round_div(longint num, longint den);
         longint mag;
         longint q;
         mag = (num < 0) ? -num : num;
         q   = (mag + den / 2) / den;
         return (num < 0) ? -q : q;
      endfunction

      function longint axis_weight(logic signed [OFF_W-1:0] off, logic [REG_W-1:0] inv);
         longint k;
         longint b;
         longint c;
         longint mag;
         longint t;
         longint t2;
         longint t3;
         longint sum;
         k   = ONE;
         b   = b_coeff;
         c   = c_coeff;
         mag = (off < 0) ? -longint'(off) : longint'(off);
         t   = (2 * mag * longint'(inv) + (longint'(1) << (OFF_FRAC - 1))) >> OFF_FRAC;
         if (t >= 2 * k)
            return 0;
         t2 = (t * t + HALF) >> FRAC_BITS;
         t3 = (t2 * t + HALF) >> FRAC_BITS;
         if (t <= k) begin
            sum = (12 * k - 9 * b - 6 * c) * t3
                + (-18 * k + 12 * b + 6 * c) * t2
                + (6 * k - 2 * b) * k;
         end else begin
            sum = (-b - 6 * c) * t3
                + (6 * b + 30 * c) * t2
                + (-12 * b - 48 * c) * t
                + (8 * b + 24 * c) * k;
         end
         return round_div(sum, 6 * k);
      endfunction

      function void note_item(logic signed [OFF_W-1:0] x, logic signed [OFF_W-1:0] y);
         longint wx;
         longint wy;
         longint w;
         wx = axis_weight(x, inv_x);
         wy = axis_weight(y, inv_y);
         w  = round_div(wx * wy, longint'(1) << FRAC_BITS);
         if (w > 32767)
            w = 32767;
         if (w < -32768)
            w = -32768;
         expected_weight.push_back(OUT_W'(w));
      endfunction

      function void check_weight(logic signed [OUT_W-1:0] actual);
         logic signed [OUT_W-1:0] want;
         if (expected_weight.size() == 0) begin
            $error("filter_weight: expected none, actual %0d", actual);
            errors++;
            return;
         end
         want = expected_weight.pop_front();
         checked++;
         if (actual !== want) begin
            $error("filter_weight: expected %0d, actual %0d", want, actual);
            errors++;
         end
      endfunction

      function int pending();
         return expected_weight.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic signed [OFF_W-1:0]  req_x_offset;
   logic signed [OFF_W-1:0]  req_y_offset;
   logic                     csr_we;
   logic [1:0]               csr_index;
   logic [REG_W-1:0]         csr_wdata;
   logic                     rsp_valid;
   logic signed [OUT_W-1:0]  rsp_filter_weight;

   weight_scoreboard sb;
   int               items_sent;
   int               burst_left;
   int               idle_cycles;

   mitchell_filter_weight_core DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_x_offset      (req_x_offset),
      .req_y_offset      (req_y_offset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_filter_weight (rsp_filter_weight)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_weight(rsp_filter_weight);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench failed");
            $finish;
         end
      end
   end

   task automatic send_item(logic signed [OFF_W-1:0] x, logic signed [OFF_W-1:0] y);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_x_offset <= x;
      req_y_offset <= y;
      start        <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_item(x, y);
      items_sent++;
   endtask

   task automatic write_reg(csr_idx_type idx, logic [REG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic load_regs(logic [REG_W-1:0] b, logic [REG_W-1:0] c,
                            logic [REG_W-1:0] ix, logic [REG_W-1:0] iy);
      write_reg(CSR_B_COEFF, b);
      write_reg(CSR_C_COEFF, c);
      write_reg(CSR_INV_X_WIDTH, ix);
      write_reg(CSR_INV_Y_WIDTH, iy);
      csr_we <= 1'b0;
      // hold off until the new settings reach the datapath
      repeat (4) @(posedge clock);
   endtask

   function automatic logic signed [OFF_W-1:0] pick_offset(logic [REG_W-1:0] inv);
      longint target;
      longint mag;
      if (inv == 0 || $urandom_range(0, 3) == 0)
         return OFF_W'($urandom_range(0, 65535));
      // aim the scaled distance at the inner piece, the outer piece or the tail
      target = $urandom_range(0, 2 * ONE + ONE / 4);
      mag    = (target * 2048) / longint'(inv);
      if (mag > 32767)
         mag = 32767;
      return OFF_W'(($urandom_range(0, 1) == 1) ? -mag : mag);
   endfunction

   initial begin
      logic signed [OFF_W-1:0] directed_x[16];
      logic signed [OFF_W-1:0] directed_y[16];
      directed_x = '{16'sd0, 16'sd4096, 16'sd4095, 16'sd4097, 16'sd8191, 16'sd8192,
                     16'sd8193, -16'sd4096, -16'sd8192, 16'sd32767, -16'sd32768,
                     -16'sd32768, 16'sd2048, 16'sd0, 16'sd0, 16'sd6000};
      directed_y = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                     16'sd0, -16'sd4096, 16'sd4096, 16'sd32767, -16'sd32768,
                     16'sd32767, -16'sd2048, 16'sd8191, -16'sd8193, -16'sd3000};
      sb           = new();
      items_sent   = 0;
      burst_left   = 0;
      reset        <= 1'b1;
      start        <= 1'b0;
      req_x_offset <= '0;
      req_y_offset <= '0;
      csr_we       <= 1'b0;
      csr_index    <= CSR_B_COEFF;
      csr_wdata    <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            start <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
         end
         case (p)
            1: load_regs(16'd0, 16'd8192, 16'd16384, 16'd16384);
            2: load_regs(16'h8000, 16'h7FFF, 16'd0, 16'hFFFF);
            3: load_regs(16'h7FFF, 16'h8000, 16'hFFFF, 16'd0);
            4, 5: load_regs(($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 65535))
                                                        : 16'($urandom_range(0, 16384)),
                            ($urandom_range(0, 1) == 1) ? 16'($urandom_range(0, 65535))
                                                        : 16'($urandom_range(0, 16384)),
                            16'($urandom_range(1, 65535)),
                            16'($urandom_range(2048, 32768)));
            default: ;
         endcase
         if (p == 0) begin
            foreach (directed_x[i])
               send_item(directed_x[i], directed_y[i]);
         end
         for (int n = 0; n < RANDOM_ITEMS; n++)
            send_item(pick_offset(sb.inv_x), pick_offset(sb.inv_y));
      end

      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (LAT) @(posedge clock);

      $display("Sent %0d offset pairs and checked %0d weights over %0d filter settings,",
               items_sent, sb.checked, PHASES);
      $display("including zero widths, full-scale widths and extreme B and C.");
      if (sb.errors == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
